// File: rtl/core/wpg_pkg.sv
// Package for the waveform point generator: shape codes, register indexes,
// field widths, fixed-point constants and the configuration struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package wpg_pkg;

  localparam int IDX_W  = 9;
  localparam int CODE_W = 12;
  localparam int LEN_W  = 11;
  localparam int SHAPE_W = 3;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam int TABLE_POINTS_DEF     = 512;
  localparam int MAX_CYCLE_POINTS_DEF = 1024;

  localparam logic [SHAPE_W-1:0] SHAPE_SINE     = 3'd0;
  localparam logic [SHAPE_W-1:0] SHAPE_SQUARE   = 3'd1;
  localparam logic [SHAPE_W-1:0] SHAPE_RAMP     = 3'd2;
  localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 3'd3;
  localparam logic [SHAPE_W-1:0] SHAPE_DC       = 3'd4;

  // Register index, taken from paddr[2].
  localparam logic REG_SHAPE  = 1'b0;
  localparam logic REG_POINTS = 1'b1;

  localparam logic [CODE_W-1:0] MID_CODE  = 12'd2048;
  localparam logic [CODE_W-1:0] FULL_CODE = 12'd4095;
  localparam logic [15:0]       HALF_Q15  = 16'd32768;
  localparam logic [17:0]       DEN_BASE  = 18'd163840;
  localparam logic [10:0]       SINE_AMP  = 11'd2047;
  localparam logic [14:0]       ROUND_Q15 = 15'd32767;

  typedef struct packed {
    logic [SHAPE_W-1:0] shape;
    logic [LEN_W-1:0]   len;
    logic [LEN_W-1:0]   half;
  } cfg_t;

endpackage
`default_nettype wire

// File: rtl/core/wpg_in_if.sv
// Input channel carrying one table position per transaction.
// Depends on wpg_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none
interface wpg_in_if;
  logic                       valid;
  logic                       ready;
  logic [wpg_pkg::IDX_W-1:0]  point_index;
  modport source (output valid, output point_index, input ready);
  modport sink   (input valid, input point_index, output ready);
endinterface
`default_nettype wire

// File: rtl/core/wpg_out_if.sv
// Output channel carrying one DAC code per transaction.
// Depends on wpg_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none
interface wpg_out_if;
  logic                        valid;
  logic                        ready;
  logic [wpg_pkg::CODE_W-1:0]  dac_code;
  modport source (output valid, output dac_code, input ready);
  modport sink   (input valid, input dac_code, output ready);
endinterface
`default_nettype wire

// File: rtl/core/wpg_cfg.sv
// APB-style register file for shape and cycle length, with the clamped
// length and half length kept ready for the datapath. Depends on wpg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wpg_cfg #(
  parameter int MAX_CYCLE_POINTS = wpg_pkg::MAX_CYCLE_POINTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [wpg_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [wpg_pkg::DATA_W-1:0]  pwdata,
  output logic      [wpg_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output wpg_pkg::cfg_t                    cfg
);
  import wpg_pkg::*;

  localparam logic [12:0] MAX_LEN = 13'(MAX_CYCLE_POINTS);

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] p);
    return ({2'b00, p} > MAX_LEN) ? LEN_W'(MAX_LEN) : p;
  endfunction

  localparam logic [LEN_W-1:0] RST_POINTS = 11'd256;

  logic [LEN_W-1:0] points;
  logic             wr;
  logic [LEN_W-1:0] new_len;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign new_len = clamp_len(pwdata[LEN_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shape <= SHAPE_SINE;
      points    <= RST_POINTS;
      cfg.len   <= clamp_len(RST_POINTS);
      cfg.half  <= clamp_len(RST_POINTS) >> 1;
    end else if (wr) begin
      unique case (paddr[2])
        REG_SHAPE:  cfg.shape <= pwdata[SHAPE_W-1:0];
        REG_POINTS: begin
          points   <= pwdata[LEN_W-1:0];
          cfg.len  <= new_len;
          cfg.half <= new_len >> 1;
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SHAPE:  prdata = DATA_W'(cfg.shape);
      REG_POINTS: prdata = DATA_W'(points);
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/wpg_pdiv.sv
// Pipelined restoring divider, one quotient bit per register stage, with a
// sideband word that travels alongside. Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none
module wpg_pdiv #(
  parameter int NW = 16,
  parameter int DW = 16,
  parameter int QW = 16,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [SW-1:0] sb_in,
  output logic               out_valid,
  output logic      [QW-1:0] quo,
  output logic      [NW-1:0] rem,
  output logic      [SW-1:0] sb_out
);
  localparam int CW = NW + DW + QW;

  // The numerator must stay below den << QW for the quotient to fit.
  logic          vld   [0:QW];
  logic [NW-1:0] rem_s [0:QW];
  logic [QW-1:0] quo_s [0:QW];
  logic [SW-1:0] sb_s  [0:QW];
  logic [DW-1:0] den_s [0:QW-1];

  assign vld[0]   = in_valid;
  assign rem_s[0] = num;
  assign quo_s[0] = '0;
  assign sb_s[0]  = sb_in;
  assign den_s[0] = den;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [CW-1:0] dsh;
    logic          take;
    assign dsh  = CW'(den_s[k]) << B;
    assign take = CW'(rem_s[k]) >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1] <= take ? NW'(CW'(rem_s[k]) - dsh) : rem_s[k];
        quo_s[k+1] <= take ? (quo_s[k] | (QW'(1) << B)) : quo_s[k];
        sb_s[k+1]  <= sb_s[k];
      end
    end

    if (k < QW - 1) begin : g_den
      always_ff @(posedge clk) begin
        if (en) begin
          den_s[k+1] <= den_s[k];
        end
      end
    end
  end

  assign out_valid = vld[QW];
  assign quo       = quo_s[QW];
  assign rem       = rem_s[QW];
  assign sb_out    = sb_s[QW];

endmodule
`default_nettype wire

// File: rtl/core/waveform_point_generator_core.sv
// An accepted point passes through the whole pipeline to its DAC code at the output.
// Throughput: one point per cycle; the whole pipeline holds while the output
// is stalled, and the input is ready whenever the output register can move.
// The depth is set by three bit-serial dividers laid out one bit per stage.
// Reset (synchronous, active high) empties the pipeline and restores the
// registers to sine shape and 256 points per cycle.
`timescale 1ns / 1ps
`default_nettype none
module waveform_point_generator_core #(
  parameter int TABLE_POINTS     = wpg_pkg::TABLE_POINTS_DEF,
  parameter int MAX_CYCLE_POINTS = wpg_pkg::MAX_CYCLE_POINTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [wpg_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [wpg_pkg::DATA_W-1:0]  pwdata,
  output logic      [wpg_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  wpg_in_if.sink                           pt_in,
  wpg_out_if.source                        code_out
);
  import wpg_pkg::*;

  cfg_t cfg;
  logic en;

  wpg_cfg #(.MAX_CYCLE_POINTS(MAX_CYCLE_POINTS)) u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  logic             vf;
  logic [CODE_W-1:0] code_f;

  assign en             = !vf || code_out.ready;
  assign pt_in.ready    = en;
  assign code_out.valid = vf;
  assign code_out.dac_code = code_f;

  // Input register.
  logic             v0;
  logic [IDX_W-1:0] idx0;
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= pt_in.valid;
  end
  always_ff @(posedge clk) begin
    if (en) idx0 <= pt_in.point_index;
  end

  // Wrap to the table length with a reciprocal multiplication over two
  // stages, then reduce by the cycle length.
  localparam int RCP_SH = 22;
  localparam int RCP_W  = 22;
  localparam logic [RCP_W-1:0] TAB_RCP = RCP_W'(((64'd1 << RCP_SH) +
    64'(TABLE_POINTS) - 64'd1) / 64'(TABLE_POINTS));
  localparam logic [12:0] TAB_LEN = 13'(TABLE_POINTS);

  logic                   vr;
  logic [IDX_W-1:0]       idx_r, quo_r;
  logic [IDX_W+RCP_W-1:0] rcp_prod;
  logic [21:0]            tab_back;

  assign rcp_prod = idx0 * TAB_RCP;
  assign tab_back = quo_r * TAB_LEN;

  always_ff @(posedge clk) begin
    if (rst) vr <= 1'b0;
    else if (en) vr <= v0;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      idx_r <= idx0;
      quo_r <= rcp_prod[RCP_SH +: IDX_W];
    end
  end

  logic             v1, v2;
  logic [IDX_W-1:0] rem0, t2;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= vr;
  end
  always_ff @(posedge clk) begin
    if (en) rem0 <= idx_r - tab_back[IDX_W-1:0];
  end

  wpg_pdiv #(.NW(IDX_W), .DW(LEN_W), .QW(IDX_W), .SW(1)) u_div_len (
    .clk, .rst, .en, .in_valid(v1), .num(rem0), .den(cfg.len),
    .sb_in(1'b0), .out_valid(v2), .quo(), .rem(t2), .sb_out()
  );

  // Operand setup for the phase, ramp or triangle division.
  logic [LEN_W-1:0] t_ext, u;
  logic [22:0]      tri_prod;
  logic             vp, sq_hi;
  logic [24:0]      num_a;
  logic [LEN_W-1:0] den_a;

  assign t_ext    = LEN_W'(t2);
  assign u        = (t_ext < cfg.half) ? t_ext : (cfg.len - t_ext);
  assign tri_prod = u * FULL_CODE;

  always_ff @(posedge clk) begin
    if (rst) vp <= 1'b0;
    else if (en) vp <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sq_hi <= t_ext < cfg.half;
      den_a <= (cfg.shape == SHAPE_TRIANGLE) ? cfg.half : cfg.len;
      case (cfg.shape)
        SHAPE_RAMP:     num_a <= 25'({t2, 12'b0});
        SHAPE_TRIANGLE: num_a <= 25'(tri_prod);
        default:        num_a <= 25'({t2, 16'b0});
      endcase
    end
  end

  logic        va, sq_a;
  logic [15:0] qa;

  wpg_pdiv #(.NW(25), .DW(LEN_W), .QW(16), .SW(1)) u_div_a (
    .clk, .rst, .en, .in_valid(vp), .num(num_a), .den(den_a),
    .sb_in(sq_hi), .out_valid(va), .quo(qa), .rem(), .sb_out(sq_a)
  );

  // Phase split into half period and sign; non-sine codes settle here.
  logic              vx, neg_x;
  logic [14:0]       xr;
  logic [CODE_W-1:0] alt_x, alt_c;

  always_comb begin
    case (cfg.shape)
      SHAPE_SQUARE:   alt_c = sq_a ? FULL_CODE : '0;
      SHAPE_RAMP:     alt_c = qa[CODE_W-1:0];
      SHAPE_TRIANGLE: begin
        if (cfg.half == '0) alt_c = MID_CODE;
        else if (qa > 16'(FULL_CODE)) alt_c = FULL_CODE;
        else alt_c = qa[CODE_W-1:0];
      end
      default:        alt_c = MID_CODE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) vx <= 1'b0;
    else if (en) vx <= va;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      neg_x <= qa[15];
      xr    <= qa[14:0];
      alt_x <= alt_c;
    end
  end

  // Bhaskara term x*(pi-x) in Q15.
  logic              vm, neg_m;
  logic [13:0]       tm;
  logic [CODE_W-1:0] alt_m;
  logic [30:0]       prod_m;

  assign prod_m = xr * (HALF_Q15 - 16'(xr));

  always_ff @(posedge clk) begin
    if (rst) vm <= 1'b0;
    else if (en) vm <= vx;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      tm    <= prod_m[28:15];
      neg_m <= neg_x;
      alt_m <= alt_x;
    end
  end

  // Numerator 16*tm in Q15 and denominator 5*pi^2 - 4*tm.
  logic              vn;
  logic [32:0]       num_b;
  logic [17:0]       den_b;
  logic [CODE_W:0]   sb_n;

  always_ff @(posedge clk) begin
    if (rst) vn <= 1'b0;
    else if (en) vn <= vm;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      num_b <= 33'(tm) << 19;
      den_b <= DEN_BASE - 18'({tm, 2'b00});
      sb_n  <= {neg_m, alt_m};
    end
  end

  logic            vb;
  logic [15:0]     qb;
  logic [CODE_W:0] sb_b;

  wpg_pdiv #(.NW(33), .DW(18), .QW(16), .SW(CODE_W + 1)) u_div_b (
    .clk, .rst, .en, .in_valid(vn), .num(num_b), .den(den_b),
    .sb_in(sb_n), .out_valid(vb), .quo(qb), .rem(), .sb_out(sb_b)
  );

  // Scale the Q15 sine to the DAC half range.
  logic              vo, neg_o;
  logic [26:0]       mq;
  logic [CODE_W-1:0] alt_o;

  always_ff @(posedge clk) begin
    if (rst) vo <= 1'b0;
    else if (en) vo <= vb;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mq    <= qb * SINE_AMP;
      neg_o <= sb_b[CODE_W];
      alt_o <= sb_b[CODE_W-1:0];
    end
  end

  // Negative offsets round toward minus infinity, as the floor of s*2047/2^15.
  logic [27:0]       mq_up;
  logic [12:0]       sine_v;
  logic [CODE_W-1:0] sine_c;
  logic              is_sine;
  logic [CODE_W-1:0] code_c;

  assign mq_up  = 28'(mq) + 28'(ROUND_Q15);
  assign sine_v = neg_o ? (13'(MID_CODE) - 13'(mq_up[27:15]))
                        : (13'(MID_CODE) + 13'(mq[26:15]));
  assign sine_c = sine_v[12] ? FULL_CODE : sine_v[CODE_W-1:0];

  always_comb begin
    case (cfg.shape)
      SHAPE_SQUARE, SHAPE_RAMP, SHAPE_TRIANGLE, SHAPE_DC: is_sine = 1'b0;
      default:                                            is_sine = 1'b1;
    endcase
    if (cfg.len == '0) code_c = MID_CODE;
    else if (is_sine) code_c = sine_c;
    else code_c = alt_o;
  end

  always_ff @(posedge clk) begin
    if (rst) vf <= 1'b0;
    else if (en) vf <= vo;
  end
  always_ff @(posedge clk) begin
    if (en) code_f <= code_c;
  end

endmodule
`default_nettype wire

// File: rtl/core/wpg_checker.sv
// Port-level checks for the waveform point generator, bound to the top level.
// Depends on wpg_pkg and waveform_point_generator_core.
`timescale 1ns / 1ps
`default_nettype none
module wpg_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [wpg_pkg::CODE_W-1:0]  dac_code,
  input wire logic                        psel,
  input wire logic                        penable,
  input wire logic                        pwrite,
  input wire logic [wpg_pkg::ADDR_W-1:0]  paddr,
  input wire logic [wpg_pkg::DATA_W-1:0]  pwdata,
  input wire logic [wpg_pkg::DATA_W-1:0]  prdata
);
  import wpg_pkg::*;

  // A held result must not change while the sink stalls.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(dac_code))
    else $error("stalled result changed or vanished");

  // The pipeline only stalls the input when a result is waiting.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output stage");

  // An accepted point never lands on a stalled output in the same cycle.
  a_flow: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !out_valid || out_ready)
    else $error("input accepted while the output was stalled");

  // A shape write reads back on the next cycle.
  a_shape_rb: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && paddr[2] == REG_SHAPE ##1 paddr[2] == REG_SHAPE
    |-> prdata[SHAPE_W-1:0] == $past(pwdata[SHAPE_W-1:0]))
    else $error("shape register readback mismatch");

endmodule

bind waveform_point_generator_core wpg_checker u_wpg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pt_in.valid),
  .in_ready  (pt_in.ready),
  .out_valid (code_out.valid),
  .out_ready (code_out.ready),
  .dac_code  (code_out.dac_code),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);
`default_nettype wire
